// File: rtl/core/assert_macros.svh
// Assertion macros used by the scanner checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SCSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Consequent holds in the clock cycle after the antecedent.
`define SCSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: rtl/core/scss_pkg.sv
// Shared constants, command codes and stage types of the display scanner.
// No dependencies.
package scss_pkg;

  localparam int unsigned TEXT_DEPTH_DEF = 16;
  localparam int unsigned DIGITS         = 4;
  localparam int unsigned DISPLAYS       = 2;
  localparam int unsigned LED_COUNT      = 4;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_BEGIN  = 3'd1;
  localparam logic [2:0] CMD_APPEND = 3'd2;
  localparam logic [2:0] CMD_LED    = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;

  localparam logic [0:0] REG_PERIOD = 1'b0;
  localparam logic [0:0] REG_LEDS   = 1'b1;

  localparam logic DISP_UPPER = 1'b0;
  localparam logic DISP_LOWER = 1'b1;

  localparam logic [3:0] SLOT_LED    = 4'd4;
  localparam logic [3:0] SLOT_UPPER0 = 4'd5;
  localparam logic [3:0] SLOT_LAST   = 4'd8;

  localparam logic [14:0] PERIOD_RST = 15'd500;
  localparam logic [2:0]  LEDS_RST   = 3'd4;
  localparam logic [15:0] COUNT_RST  = 16'd1000;

  localparam logic [7:0] LOWER_SEL [DIGITS] = '{8'h10, 8'h20, 8'h40, 8'h80};
  localparam logic [7:0] UPPER_SEL [DIGITS] = '{8'h01, 8'h02, 8'h04, 8'h08};

  typedef struct packed {
    logic       tick;
    logic       seg_mem;
    logic [7:0] sel_a;
    logic [7:0] sel_b;
    logic [3:0] slot;
  } scss_meta_t;

endpackage

// File: rtl/core/scrolling_seven_segment_scanner.sv
// Top level of the scrolling seven-segment scanner.
// Depends on scss_pkg, scss_ctrl, scss_text_mem, scss_pipe.
//
//   channel  direction  handshake                fields
//   in       input      in_valid_i / in_stall_o  command, display_sel, segments, led_index, led_on
//   out      output     out_valid_o / out_stall_i segment_port, select ports, scan_slot
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle while in_stall_o is low; its result passes the read stage and then the output register.
// The text store read is registered, so the segment byte is taken in the second stage.
// Reset clears scan, scroll and LED state and the latches; the text store is not cleared.
// A stall on the output backs up through the read stage to in_stall_o in the same cycle.
module scrolling_seven_segment_scanner import scss_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic        display_sel_i,
  input  logic [7:0]  segments_i,
  input  logic [1:0]  led_index_i,
  input  logic        led_on_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  segment_port_o,
  output logic [7:0]  select_port_a_o,
  output logic [7:0]  select_port_b_o,
  output logic [3:0]  scan_slot_o
);

  localparam int unsigned AW = $clog2(TEXT_DEPTH) + 1;

  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;
  scss_meta_t    meta;

  assign cfg_ready_o = 1'b1;

  scss_ctrl #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .command_i    (command_i),
    .display_sel_i(display_sel_i),
    .segments_i   (segments_i),
    .led_index_i  (led_index_i),
    .led_on_i     (led_on_i),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .meta_o       (meta)
  );

  scss_text_mem #(
    .TEXT_DEPTH(TEXT_DEPTH)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  scss_pipe u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .accept_o       (accept),
    .meta_i         (meta),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .segment_port_o (segment_port_o),
    .select_port_a_o(select_port_a_o),
    .select_port_b_o(select_port_b_o),
    .scan_slot_o    (scan_slot_o)
  );

endmodule

// File: rtl/core/scss_text_mem.sv
// Text store for both displays: one write port, one registered read port.
// Depends on scss_pkg.
module scss_text_mem import scss_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TEXT_DEPTH) + 1
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem [2**AW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/scss_ctrl.sv
// Scan control: config registers, scroll state, slot counter, select latches,
// text store addressing. Depends on scss_pkg.
module scss_ctrl import scss_pkg::*; #(
  parameter int unsigned TEXT_DEPTH = TEXT_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TEXT_DEPTH) + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [14:0]   cfg_data_i,
  input  logic          accept_i,
  input  logic [2:0]    command_i,
  input  logic          display_sel_i,
  input  logic [7:0]    segments_i,
  input  logic [1:0]    led_index_i,
  input  logic          led_on_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [7:0]    wr_data_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  output scss_meta_t    meta_o
);

  localparam int unsigned PW = AW - 1;
  localparam int unsigned LW = $clog2(TEXT_DEPTH + 1);
  localparam int unsigned OW = $clog2(TEXT_DEPTH + DIGITS);
  localparam int unsigned CW = $clog2(TEXT_DEPTH + 2 * DIGITS);
  localparam logic [LW-1:0] LEN_FULL = LW'(TEXT_DEPTH);
  localparam logic [LW-1:0] LEN_DIG  = LW'(DIGITS);

  logic [14:0]   period_q, period_d;
  logic [2:0]    leds_used_q, leds_used_d;
  logic [3:0]    slot_q, slot_d;
  logic [LW-1:0] len_q [DISPLAYS];
  logic [LW-1:0] len_d [DISPLAYS];
  logic [OW-1:0] off_q [DISPLAYS];
  logic [OW-1:0] off_d [DISPLAYS];
  logic [LED_COUNT-1:0] led_q, led_d;
  logic [15:0]   cnt_q, cnt_d;
  logic          due_q, due_d;
  logic [7:0]    sel_a_q, sel_a_d;
  logic [7:0]    sel_b_q, sel_b_d;

  logic [14:0]   eff_period;
  logic [15:0]   reload_cnt;
  logic [DISPLAYS-1:0] can_scroll;
  logic [OW-1:0] off_tick [DISPLAYS];
  logic [CW-1:0] nx;
  logic          scrolled;
  logic          is_lower, is_led, is_tick;
  logic [1:0]    dig;
  logic          disp;
  logic [CW-1:0] pos;
  logic          blank;
  logic [2:0]    led_n;
  logic [LED_COUNT-1:0] led_bits;
  logic [15:0]   cnt_base, cnt_tick;
  logic          due_tick;
  logic [3:0]    slot_next;
  logic          sel;
  logic          can_append;
  scss_meta_t    meta;

  always_comb begin
    eff_period = (period_q == '0) ? 15'd1 : period_q;
    reload_cnt = {eff_period, 1'b0};

    for (int i = 0; i < DISPLAYS; i++) begin
      can_scroll[i] = len_q[i] > LEN_DIG;
      nx = CW'(off_q[i]) + CW'(1);
      if (nx >= CW'(len_q[i]) + CW'(DIGITS)) begin
        nx = '0;
      end
      off_tick[i] = (due_q && can_scroll[i]) ? OW'(nx) : off_q[i];
    end
    scrolled = due_q && (|can_scroll);

    is_lower = slot_q < SLOT_LED;
    is_led   = slot_q == SLOT_LED;
    is_tick  = command_i == CMD_TICK;
    dig      = is_lower ? slot_q[1:0] : 2'(slot_q - SLOT_UPPER0);
    disp     = is_lower ? DISP_LOWER : DISP_UPPER;
    pos      = CW'(off_tick[disp]) + CW'(dig);
    blank    = pos >= CW'(len_q[disp]);

    led_n = (leds_used_q > 3'(LED_COUNT)) ? 3'(LED_COUNT) : leds_used_q;
    for (int k = 0; k < LED_COUNT; k++) begin
      led_bits[k] = led_q[k] && (3'(k) < led_n);
    end

    meta.tick    = is_tick;
    meta.seg_mem = 1'b0;
    meta.sel_a   = sel_a_q;
    meta.sel_b   = sel_b_q;
    meta.slot    = slot_q;
    if (is_tick) begin
      if (is_lower) begin
        meta.seg_mem = !blank;
        if (!slot_q[1]) begin
          meta.sel_a = LOWER_SEL[dig];
          meta.sel_b = '0;
        end else begin
          meta.sel_a = '0;
          meta.sel_b = LOWER_SEL[dig];
        end
      end else if (is_led) begin
        if (led_n != '0) begin
          meta.sel_a = 8'(led_bits);
        end
      end else begin
        meta.seg_mem = !blank;
        meta.sel_a   = UPPER_SEL[dig];
        meta.sel_b   = '0;
      end
    end

    cnt_base = scrolled ? {1'b0, eff_period} : cnt_q;
    if (cnt_base <= 16'd1) begin
      cnt_tick = {1'b0, eff_period};
      due_tick = 1'b1;
    end else begin
      cnt_tick = cnt_base - 16'd1;
      due_tick = due_q && !scrolled;
    end
    slot_next = (slot_q >= SLOT_LAST) ? '0 : slot_q + 4'd1;

    sel        = display_sel_i;
    can_append = len_q[sel] < LEN_FULL;
  end

  assign wr_en_o   = accept_i && (command_i == CMD_APPEND) && can_append;
  assign wr_addr_o = {sel, len_q[sel][PW-1:0]};
  assign wr_data_o = segments_i;
  assign rd_en_o   = accept_i && meta.seg_mem;
  assign rd_addr_o = {disp, pos[PW-1:0]};
  assign meta_o    = meta;

  always_comb begin
    period_d    = period_q;
    leds_used_d = leds_used_q;
    slot_d      = slot_q;
    len_d       = len_q;
    off_d       = off_q;
    led_d       = led_q;
    cnt_d       = cnt_q;
    due_d       = due_q;
    sel_a_d     = sel_a_q;
    sel_b_d     = sel_b_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PERIOD: period_d    = cfg_data_i;
        REG_LEDS:   leds_used_d = cfg_data_i[2:0];
        default:    period_d    = period_q;
      endcase
    end

    if (accept_i) begin
      unique case (command_i)
        CMD_TICK: begin
          off_d   = off_tick;
          cnt_d   = cnt_tick;
          due_d   = due_tick;
          slot_d  = slot_next;
          sel_a_d = meta.sel_a;
          sel_b_d = meta.sel_b;
        end
        CMD_BEGIN: begin
          if (len_q[sel] > LEN_DIG) begin
            for (int i = 0; i < DISPLAYS; i++) begin
              off_d[i] = '0;
            end
            cnt_d = reload_cnt;
            due_d = 1'b0;
          end
          len_d[sel] = '0;
        end
        CMD_APPEND: begin
          if (can_append) begin
            len_d[sel] = len_q[sel] + LW'(1);
          end
        end
        CMD_LED: begin
          led_d[led_index_i] = led_on_i;
        end
        CMD_CLEAR: begin
          for (int i = 0; i < DISPLAYS; i++) begin
            off_d[i] = '0;
            len_d[i] = '0;
          end
          cnt_d = reload_cnt;
          due_d = 1'b0;
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      leds_used_q <= LEDS_RST;
      slot_q      <= '0;
      for (int i = 0; i < DISPLAYS; i++) begin
        len_q[i] <= '0;
        off_q[i] <= '0;
      end
      led_q   <= '0;
      cnt_q   <= COUNT_RST;
      due_q   <= 1'b0;
      sel_a_q <= '0;
      sel_b_q <= '0;
    end else begin
      period_q    <= period_d;
      leds_used_q <= leds_used_d;
      slot_q      <= slot_d;
      len_q       <= len_d;
      off_q       <= off_d;
      led_q       <= led_d;
      cnt_q       <= cnt_d;
      due_q       <= due_d;
      sel_a_q     <= sel_a_d;
      sel_b_q     <= sel_b_d;
    end
  end

endmodule

// File: rtl/core/scss_pipe.sv
// Read stage and output register with handshake; holds the segment latch.
// Depends on scss_pkg.
module scss_pipe import scss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       accept_o,
  input  scss_meta_t meta_i,
  input  logic [7:0] rd_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] segment_port_o,
  output logic [7:0] select_port_a_o,
  output logic [7:0] select_port_b_o,
  output logic [3:0] scan_slot_o
);

  logic       s1_valid_q, s1_valid_d;
  scss_meta_t meta_q;
  logic [7:0] seg_q, seg_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_seg_q, out_a_q, out_b_q;
  logic [3:0] out_slot_q;
  logic       out_ready, s1_adv;

  always_comb begin
    out_ready   = !out_valid_q || !out_stall_i;
    s1_adv      = s1_valid_q && out_ready;
    in_stall_o  = s1_valid_q && !out_ready;
    accept_o    = in_valid_i && !in_stall_o;
    s1_valid_d  = accept_o || (s1_valid_q && !s1_adv);
    out_valid_d = s1_adv || (out_valid_q && out_stall_i);
    if (meta_q.tick) begin
      seg_d = meta_q.seg_mem ? rd_data_i : '0;
    end else begin
      seg_d = seg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seg_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        seg_q <= seg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_o) begin
      meta_q <= meta_i;
    end
    if (s1_adv) begin
      out_seg_q  <= seg_d;
      out_a_q    <= meta_q.sel_a;
      out_b_q    <= meta_q.sel_b;
      out_slot_q <= meta_q.slot;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_port_o  = out_seg_q;
  assign select_port_a_o = out_a_q;
  assign select_port_b_o = out_b_q;
  assign scan_slot_o     = out_slot_q;

endmodule

// File: rtl/core/scss_checker.sv
// Port-level checks for the scanner, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module scss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  segment_port_o,
  input logic [7:0]  select_port_a_o,
  input logic [7:0]  select_port_b_o,
  input logic [3:0]  scan_slot_o
);

  // Input side only backs up when the output is full and stalled.
  `SCSS_ASSERT(a_stall_src, clk_i, rst_ni, !in_stall_o || (out_valid_o && out_stall_i))
  `SCSS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(segment_port_o) && $stable(select_port_a_o) && $stable(select_port_b_o) && $stable(scan_slot_o))
  `SCSS_ASSERT(a_slot_range, clk_i, rst_ni, !out_valid_o || (scan_slot_o <= 4'd8))
  `SCSS_ASSERT(a_sel_b_onehot, clk_i, rst_ni, !out_valid_o || (select_port_b_o == 8'd0) || $onehot(select_port_b_o))

endmodule

bind scrolling_seven_segment_scanner scss_checker u_scss_checker (.*);

// File: tb/scrolling_seven_segment_scanner_test.sv
// Testbench for the scrolling seven-segment scanner: directed and random requests are
// checked against an in-bench model of the scan, scroll, text and LED logic.
// Depends on scss_pkg and scrolling_seven_segment_scanner.
`timescale 1ns / 1ps

module scrolling_seven_segment_scanner_test;
  import scss_pkg::*;

  localparam int unsigned TDEPTH      = TEXT_DEPTH_DEF;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic       display_sel;
    logic [7:0] segments;
    logic [1:0] led_index;
    logic       led_on;
  } scan_req_t;

  typedef struct packed {
    logic [7:0] segment_port;
    logic [7:0] select_port_a;
    logic [7:0] select_port_b;
    logic [3:0] scan_slot;
  } scan_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_PERIOD;
  logic [14:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  scan_req_t   req_q = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  segment_port;
  logic [7:0]  select_port_a;
  logic [7:0]  select_port_b;
  logic [3:0]  scan_slot;

  scrolling_seven_segment_scanner uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (req_q.command),
    .display_sel_i  (req_q.display_sel),
    .segments_i     (req_q.segments),
    .led_index_i    (req_q.led_index),
    .led_on_i       (req_q.led_on),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .segment_port_o (segment_port),
    .select_port_a_o(select_port_a),
    .select_port_b_o(select_port_b),
    .scan_slot_o    (scan_slot)
  );

  // model state
  logic [14:0] m_period;
  logic [2:0]  m_leds;
  logic [3:0]  m_slot;
  logic [7:0]  m_text [DISPLAYS][TDEPTH];
  int          m_len [DISPLAYS];
  int          m_off [DISPLAYS];
  logic [3:0]  m_led_bits;
  int          m_count;
  bit          m_due;
  logic [7:0]  m_seg_l, m_a_l, m_b_l;

  scan_view_t  pending_views[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          hold_len = 0;
  int          burst_left = 0;
  bit          stall_on = 1'b1;
  bit          gap_on = 1'b1;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int period_ticks();
    return (m_period == '0) ? 1 : int'(m_period);
  endfunction

  function automatic void restart_scroll();
    for (int i = 0; i < DISPLAYS; i++) m_off[i] = 0;
    m_count = (period_ticks() * 2) & 16'hFFFF;
    m_due = 1'b0;
  endfunction

  function automatic logic [7:0] digit_byte(int disp, int d);
    int pos;
    pos = m_off[disp] + d;
    if (pos < m_len[disp] && pos < TDEPTH) return m_text[disp][pos];
    return 8'h00;
  endfunction

  function automatic void reset_model();
    m_period = PERIOD_RST;
    m_leds = LEDS_RST;
    m_slot = '0;
    for (int i = 0; i < DISPLAYS; i++) begin
      m_len[i] = 0;
      for (int j = 0; j < TDEPTH; j++) m_text[i][j] = 8'h00;
    end
    m_led_bits = '0;
    m_seg_l = '0;
    m_a_l = '0;
    m_b_l = '0;
    restart_scroll();
  endfunction

  function automatic scan_view_t predict_scan(scan_req_t r);
    scan_view_t v;
    int slot;
    int n;
    int nx;
    bit scrolled;
    if (m_slot > SLOT_LAST) m_slot = '0;
    if (r.command != CMD_TICK) begin
      case (r.command)
        CMD_BEGIN: begin
          if (m_len[r.display_sel] > DIGITS) restart_scroll();
          m_len[r.display_sel] = 0;
        end
        CMD_APPEND: begin
          if (m_len[r.display_sel] < TDEPTH) begin
            m_text[r.display_sel][m_len[r.display_sel]] = r.segments;
            m_len[r.display_sel]++;
          end
        end
        CMD_LED: m_led_bits[r.led_index] = r.led_on;
        CMD_CLEAR: begin
          restart_scroll();
          for (int i = 0; i < DISPLAYS; i++) m_len[i] = 0;
        end
        default: ;
      endcase
      v = '{m_seg_l, m_a_l, m_b_l, m_slot};
      return v;
    end
    if (m_due) begin
      scrolled = 1'b0;
      for (int i = 0; i < DISPLAYS; i++) begin
        if (m_len[i] > DIGITS) begin
          nx = m_off[i] + 1;
          if (nx >= m_len[i] + DIGITS) nx = 0;
          m_off[i] = nx;
          scrolled = 1'b1;
        end
      end
      if (scrolled) begin
        m_due = 1'b0;
        m_count = period_ticks();
      end
    end
    slot = m_slot;
    if (slot < SLOT_LED) begin
      if (slot < 2) begin
        m_a_l = 8'h10 << slot;
        m_b_l = 8'h00;
      end else begin
        m_a_l = 8'h00;
        m_b_l = 8'h10 << slot;
      end
      m_seg_l = digit_byte(DISP_LOWER, slot);
    end else if (slot == SLOT_LED) begin
      n = (m_leds > LED_COUNT) ? LED_COUNT : m_leds;
      m_seg_l = 8'h00;
      if (n > 0) m_a_l = 8'(int'(m_led_bits) & ((1 << n) - 1));
    end else begin
      m_a_l = 8'h01 << (slot - SLOT_UPPER0);
      m_b_l = 8'h00;
      m_seg_l = digit_byte(DISP_UPPER, slot - SLOT_UPPER0);
    end
    m_slot = (slot >= SLOT_LAST) ? 4'd0 : 4'(slot + 1);
    if (m_count <= 1) begin
      m_due = 1'b1;
      m_count = period_ticks();
    end else begin
      m_count--;
    end
    v = '{m_seg_l, m_a_l, m_b_l, 4'(slot)};
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    scan_view_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        if (cfg_index == REG_PERIOD) m_period = cfg_data;
        else m_leds = cfg_data[2:0];
      end
      if (in_valid && in_stall === 1'b0) pending_views.push_back(predict_scan(req_q));
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_views.size() == 0) begin
          $error("result with no pending request: seg %0h a %0h b %0h slot %0d",
                 segment_port, select_port_a, select_port_b, scan_slot);
          mismatches++;
        end else begin
          want = pending_views.pop_front();
          if (segment_port !== want.segment_port) begin
            $error("segment_port: expected %0h, got %0h", want.segment_port, segment_port);
            mismatches++;
          end
          if (select_port_a !== want.select_port_a) begin
            $error("select_port_a: expected %0h, got %0h", want.select_port_a, select_port_a);
            mismatches++;
          end
          if (select_port_b !== want.select_port_b) begin
            $error("select_port_b: expected %0h, got %0h", want.select_port_b, select_port_b);
            mismatches++;
          end
          if (scan_slot !== want.scan_slot) begin
            $error("scan_slot: expected %0d, got %0d", want.scan_slot, scan_slot);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL scrolling_seven_segment_scanner");
      $finish;
    end
  end

  // output stall: long hold-off on request, else short random bursts
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        hold_len--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (stall_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic scan_req_t mk_req(logic [2:0] cmd, logic sel, logic [7:0] seg,
                                       logic [1:0] idx, logic on);
    scan_req_t r;
    r = '{cmd, sel, seg, idx, on};
    return r;
  endfunction

  function automatic scan_req_t rand_req(logic [2:0] cmd);
    return mk_req(cmd, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_req(scan_req_t r);
    int gap;
    if (gap_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_q <= r;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [14:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_text(logic sel, int len);
    scan_req_t r;
    r = rand_req(CMD_BEGIN);
    r.display_sel = sel;
    send_req(r);
    repeat (len) begin
      r = rand_req(CMD_APPEND);
      r.display_sel = sel;
      send_req(r);
    end
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_req(rand_req(CMD_TICK));
  endtask

  // mostly text runs followed by scanning, some raw noise
  task automatic send_mixed(int count);
    int sent;
    int t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 9) == 0) send_req(rand_req(CMD_CLEAR));
        t = $urandom_range(0, TDEPTH + 2);
        send_text(1'($urandom_range(0, 1)), t);
        sent += t + 1;
        t = $urandom_range(5, 40);
        repeat (t) begin
          if ($urandom_range(0, 7) == 0) send_req(rand_req(CMD_LED));
          else send_req(rand_req(CMD_TICK));
        end
        sent += t;
      end else begin
        t = $urandom_range(1, 8);
        repeat (t) send_req(rand_req(3'($urandom_range(0, 7))));
        sent += t;
      end
    end
  endtask

  task automatic test_directed();
    send_ticks(2);
    send_req(mk_req(CMD_APPEND, DISP_LOWER, 8'hFF, 2'd0, 1'b0));
    send_req(mk_req(CMD_APPEND, DISP_LOWER, 8'h00, 2'd3, 1'b1));
    send_req(mk_req(CMD_APPEND, DISP_LOWER, 8'h80, 2'd1, 1'b0));
    send_req(mk_req(CMD_APPEND, DISP_UPPER, 8'h7F, 2'd2, 1'b1));
    send_req(mk_req(CMD_LED, DISP_UPPER, 8'h00, 2'd0, 1'b1));
    send_req(mk_req(CMD_LED, DISP_LOWER, 8'hFF, 2'd3, 1'b1));
    send_req(mk_req(CMD_LED, DISP_UPPER, 8'h55, 2'd1, 1'b0));
    send_req(mk_req(CMD_SPARE_LO, DISP_LOWER, 8'hAA, 2'd2, 1'b1));
    send_req(mk_req(CMD_SPARE_HI, DISP_UPPER, 8'h01, 2'd1, 1'b0));
    send_ticks(9);
    send_req(mk_req(CMD_BEGIN, DISP_LOWER, 8'h00, 2'd0, 1'b0));
    send_req(mk_req(CMD_CLEAR, DISP_UPPER, 8'h00, 2'd0, 1'b0));
    send_ticks(2);
  endtask

  task automatic test_led_slot();
    logic [2:0] counts [7];
    counts = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd7};
    foreach (counts[i]) begin
      write_reg(REG_LEDS, {12'($urandom_range(0, 4095)), counts[i]});
      repeat (4) send_req(rand_req(CMD_LED));
      send_ticks(9);
    end
    write_reg(REG_LEDS, {12'h000, LEDS_RST});
  endtask

  task automatic test_scroll();
    write_reg(REG_PERIOD, 15'd0);
    send_req(rand_req(CMD_CLEAR));
    send_text(DISP_UPPER, TDEPTH + 2);
    send_text(DISP_LOWER, 6);
    send_ticks(60);
    send_text(DISP_UPPER, 0);
    send_ticks(10);
    write_reg(REG_PERIOD, 15'd2);
    send_req(rand_req(CMD_CLEAR));
    send_text(DISP_LOWER, 5);
    send_ticks(40);
    write_reg(REG_PERIOD, 15'h7FFF);
    send_req(rand_req(CMD_CLEAR));
    send_text(DISP_UPPER, 8);
    send_ticks(20);
  endtask

  task automatic test_random();
    logic [14:0] periods [6];
    periods = '{15'd1, 15'd3, 15'd2, 15'd11, 15'($urandom_range(1, 32767)), 15'd0};
    foreach (periods[i]) begin
      write_reg(REG_PERIOD, periods[i]);
      write_reg(REG_LEDS, {12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7))});
      send_mixed(100);
    end
  endtask

  task automatic test_backpressure();
    hold_len = HOLD_CYCLES;
    send_mixed(40);
  endtask

  task automatic test_sender_pause();
    send_mixed(20);
    drain();
    send_mixed(20);
  endtask

  task automatic test_final_stretch();
    stall_on = 1'b0;
    gap_on = 1'b0;
    send_mixed(60);
    drain();
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_led_slot();
    test_scroll();
    test_random();
    test_backpressure();
    test_sender_pause();
    test_final_stretch();
    if (mismatches == 0) $display("PASS scrolling_seven_segment_scanner");
    else $display("FAIL scrolling_seven_segment_scanner");
    $finish;
  end

endmodule
